### src/mtf_pkg.sv
// Shared types and constants for the minimum-tracking FIFO.
package mtf_pkg;

  // Default number of entry cells (and minimum-chain cells)
  localparam int unsigned DefaultDepth = 256;

  // Widths of the beat fields
  localparam int unsigned KeyW = 32;
  localparam int unsigned ObjW = 32;

  typedef logic signed [KeyW-1:0] key_t;
  typedef logic [ObjW-1:0]        obj_t;

  // Minimum reported while the queue holds nothing
  localparam key_t EmptyMin = key_t'(10000);

  // Operation code carried in func
  typedef enum logic {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } op_e;

  // Result status
  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  // Per-cycle command broadcast to every cell of a chain
  typedef struct packed {
    logic push;  // append a new key at the rear
    logic pop;   // every cell takes its right neighbor's contents
  } cell_ctrl_t;

endpackage

### src/min_tracking_fifo.sv
// Top level: FIFO of (key, object) beats that reports its minimum key.
//
//   channel  direction  handshake                 payload
//   in       sink       in_valid_i / in_stall_o   func_i, key_in_i, object_in_i
//   out      source     out_valid_o / out_stall_i status_o, object_out_o,
//                                                 min_key_o, empty_res_o
//
// All cells of both chains update at the accepting edge and the result is
// registered at that same edge.
// A new beat is taken every cycle unless a registered result is stalled.
// Reset clears the valid flags of every cell and of the result register.
// Stores hold no reset value; a cell is read only while its flag is set.
module min_tracking_fifo #(
  parameter int unsigned DEPTH = mtf_pkg::DefaultDepth
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  func_i,
  input  logic signed [31:0]    key_in_i,
  input  logic        [31:0]    object_in_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic        [1:0]     status_o,
  output logic        [31:0]    object_out_o,
  output logic signed [31:0]    min_key_o,
  output logic                  empty_res_o
);

  logic          ent_valid   [DEPTH];
  logic          ent_valid_d [DEPTH];
  mtf_pkg::key_t ent_key     [DEPTH];
  mtf_pkg::obj_t ent_obj     [DEPTH];

  logic          min_kept    [DEPTH];
  logic          min_valid   [DEPTH];
  logic          min_valid_d [DEPTH];
  mtf_pkg::key_t min_key     [DEPTH];
  mtf_pkg::key_t min_key_d   [DEPTH];

  mtf_pkg::cell_ctrl_t ent_ctrl, min_ctrl;

  logic    accept, is_enq, full, empty;
  logic    out_valid_q, out_valid_d;
  logic    empty_res_q;
  logic [1:0]    status_q, status_d;
  mtf_pkg::obj_t obj_q, obj_d;
  mtf_pkg::key_t min_q, min_d;

  // Input handshake: the output register parts the two sides
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign is_enq     = (mtf_pkg::op_e'(func_i) == mtf_pkg::OP_ENQ);
  assign full       = ent_valid[DEPTH-1];
  assign empty      = !ent_valid[0];

  // Chain commands
  always_comb begin
    ent_ctrl.push = accept && is_enq && !full;
    ent_ctrl.pop  = accept && !is_enq && !empty;
    min_ctrl.push = ent_ctrl.push;
    min_ctrl.pop  = ent_ctrl.pop && min_valid[0] && (min_key[0] == ent_key[0]);
  end

  // Cell rows
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic          left_valid, left_kept, r_ent_valid, r_min_valid;
    mtf_pkg::key_t r_ent_key, r_min_key;
    mtf_pkg::obj_t r_ent_obj;

    if (i == 0) begin : g_first
      assign left_valid = 1'b1;
      assign left_kept  = 1'b1;
    end else begin : g_mid
      assign left_valid = ent_valid[i-1];
      assign left_kept  = min_kept[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign r_ent_valid = 1'b0;
      assign r_ent_key   = '0;
      assign r_ent_obj   = '0;
      assign r_min_valid = 1'b0;
      assign r_min_key   = '0;
    end else begin : g_body
      assign r_ent_valid = ent_valid[i+1];
      assign r_ent_key   = ent_key[i+1];
      assign r_ent_obj   = ent_obj[i+1];
      assign r_min_valid = min_valid[i+1];
      assign r_min_key   = min_key[i+1];
    end

    mtf_entry_cell u_ent (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ent_ctrl),
      .left_valid_i (left_valid),
      .right_valid_i(r_ent_valid),
      .right_key_i  (r_ent_key),
      .right_obj_i  (r_ent_obj),
      .key_in_i     (key_in_i),
      .obj_in_i     (object_in_i),
      .valid_o      (ent_valid[i]),
      .valid_d_o    (ent_valid_d[i]),
      .key_o        (ent_key[i]),
      .obj_o        (ent_obj[i])
    );

    mtf_min_cell u_min (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (min_ctrl),
      .left_kept_i  (left_kept),
      .right_valid_i(r_min_valid),
      .right_key_i  (r_min_key),
      .key_in_i     (key_in_i),
      .kept_o       (min_kept[i]),
      .valid_o      (min_valid[i]),
      .valid_d_o    (min_valid_d[i]),
      .key_o        (min_key[i]),
      .key_d_o      (min_key_d[i])
    );
  end

  // Result beat: object from the front cell, minimum and empty flag from the front cells' next state
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    status_d    = mtf_pkg::STAT_OK;
    obj_d       = '0;
    if (accept) begin
      out_valid_d = 1'b1;
      if (is_enq && full) begin
        status_d = mtf_pkg::STAT_FULL;
      end else if (!is_enq && empty) begin
        status_d = mtf_pkg::STAT_EMPTY;
      end else if (!is_enq) begin
        obj_d = ent_obj[0];
      end
    end
    min_d = (!ent_valid_d[0] || !min_valid_d[0]) ? mtf_pkg::EmptyMin : min_key_d[0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q    <= status_d;
      obj_q       <= obj_d;
      min_q       <= min_d;
      empty_res_q <= !ent_valid_d[0];
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign object_out_o = obj_q;
  assign min_key_o    = min_q;
  assign empty_res_o  = empty_res_q;

`ifndef SYNTHESIS
  // The minimum chain never holds a key while the FIFO is empty
  a_min_needs_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    min_valid[0] |-> ent_valid[0])
    else $error("minimum chain holds a key while the FIFO is empty");

  // The tracked minimum never exceeds the front entry's key
  a_min_le_front: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (min_valid[0] && ent_valid[0]) |-> !(min_key[0] > ent_key[0]))
    else $error("tracked minimum above the front key");

  // A dequeue from an empty FIFO reports the empty status
  a_deq_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !is_enq && empty) |=>
      (out_valid_o && status_o == mtf_pkg::STAT_EMPTY))
    else $error("dequeue from empty not flagged");

  // An empty queue reports the fixed minimum
  a_empty_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && empty_res_o) |-> (min_key_o == mtf_pkg::EmptyMin))
    else $error("empty queue reports a key");
`endif

endmodule

### src/mtf_entry_cell.sv
// One storage cell of the FIFO chain: key, object and a valid flag.
module mtf_entry_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mtf_pkg::cell_ctrl_t ctrl_i,
  input  logic                left_valid_i,
  input  logic                right_valid_i,
  input  mtf_pkg::key_t       right_key_i,
  input  mtf_pkg::obj_t       right_obj_i,
  input  mtf_pkg::key_t       key_in_i,
  input  mtf_pkg::obj_t       obj_in_i,
  output logic                valid_o,
  output logic                valid_d_o,
  output mtf_pkg::key_t       key_o,
  output mtf_pkg::obj_t       obj_o
);

  logic          valid_q, valid_d;
  mtf_pkg::key_t key_q, key_d;
  mtf_pkg::obj_t obj_q, obj_d;

  // Pop shifts toward the front; push fills the first empty cell
  always_comb begin
    valid_d = valid_q;
    key_d   = key_q;
    obj_d   = obj_q;
    if (ctrl_i.pop) begin
      valid_d = right_valid_i;
      key_d   = right_key_i;
      obj_d   = right_obj_i;
    end else if (ctrl_i.push && !valid_q && left_valid_i) begin
      valid_d = 1'b1;
      key_d   = key_in_i;
      obj_d   = obj_in_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    obj_q <= obj_d;
  end

  assign valid_o   = valid_q;
  assign valid_d_o = valid_d;
  assign key_o     = key_q;
  assign obj_o     = obj_q;

endmodule

### src/mtf_min_cell.sv
// One cell of the nondecreasing minimum chain.
module mtf_min_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mtf_pkg::cell_ctrl_t ctrl_i,
  input  logic                left_kept_i,
  input  logic                right_valid_i,
  input  mtf_pkg::key_t       right_key_i,
  input  mtf_pkg::key_t       key_in_i,
  output logic                kept_o,
  output logic                valid_o,
  output logic                valid_d_o,
  output mtf_pkg::key_t       key_o,
  output mtf_pkg::key_t       key_d_o
);

  logic          valid_q, valid_d;
  mtf_pkg::key_t key_q, key_d;
  logic          kept;

  // Survives a push when it holds a key not above the new one; since the
  // chain is sorted, survivors form a prefix
  assign kept = valid_q && !(key_q > key_in_i);

  // Pop shifts toward the front; push drops larger keys and the first
  // dropped (or empty) cell after the survivors takes the new key
  always_comb begin
    valid_d = valid_q;
    key_d   = key_q;
    if (ctrl_i.pop) begin
      valid_d = right_valid_i;
      key_d   = right_key_i;
    end else if (ctrl_i.push && !kept) begin
      valid_d = left_kept_i;
      key_d   = key_in_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  assign kept_o    = kept;
  assign valid_o   = valid_q;
  assign valid_d_o = valid_d;
  assign key_o     = key_q;
  assign key_d_o   = key_d;

endmodule

### tb/sv/tb.sv
// Testbench for min_tracking_fifo: queue-fed driver, scoreboard monitor, queue-based predictor.
`timescale 1ns / 100ps

module tb;
  import mtf_pkg::*;

  localparam int unsigned Depth = DefaultDepth;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned TailCycles = 10;
  localparam int unsigned RandPerPhase = 170;
  localparam int unsigned NumPhases = 4;

  // One input beat
  typedef struct {
    op_e  func;
    key_t key;
    obj_t obj;
  } beat_t;

  // One result beat
  typedef struct {
    status_e status;
    obj_t    obj;
    key_t    min_key;
    logic    empty;
  } result_t;

  // Entry held in the predicted queue
  typedef struct {
    key_t key;
    obj_t obj;
  } entry_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        func_i = 1'b0;
  logic [31:0] key_in_i = '0;
  logic [31:0] object_in_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  status_o;
  logic [31:0] object_out_o;
  logic [31:0] min_key_o;
  logic        empty_res_o;

  beat_t   pending_beats[$];
  result_t expected_results[$];
  entry_t  model_entries[$];
  key_t    model_mins[$];

  beat_t       next_beat;
  result_t     want;
  bit          beat_taken = 1'b0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_req = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;

  min_tracking_fifo #(.DEPTH(Depth)) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .func_i      (func_i),
    .key_in_i    (key_in_i),
    .object_in_i (object_in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .object_out_o(object_out_o),
    .min_key_o   (min_key_o),
    .empty_res_o (empty_res_o)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predicted FIFO with monotonic minimum deque
  function automatic result_t fifo_min_step(op_e f, key_t k, obj_t o);
    result_t r;
    entry_t  head;
    r.status = STAT_OK;
    r.obj    = '0;
    if (f == OP_ENQ) begin
      if (model_entries.size() >= Depth) begin
        r.status = STAT_FULL;
      end else begin
        model_entries.push_back('{key: k, obj: o});
        // only strictly larger keys leave; equal keys keep their own slot
        while (model_mins.size() != 0 && model_mins[$] > k) void'(model_mins.pop_back());
        model_mins.push_back(k);
      end
    end else begin
      if (model_entries.size() == 0) begin
        r.status = STAT_EMPTY;
      end else begin
        head  = model_entries.pop_front();
        r.obj = head.obj;
        if (model_mins.size() != 0 && model_mins[0] == head.key) void'(model_mins.pop_front());
      end
    end
    r.empty   = (model_entries.size() == 0);
    r.min_key = (model_entries.size() == 0 || model_mins.size() == 0) ? EmptyMin : model_mins[0];
    return r;
  endfunction

  task automatic note_failure(string what);
    fail_count++;
    if (fail_count <= 10) $display("%0t: %s", $realtime, what);
  endtask

  // Driver: new beat only when the line is idle or the last beat was taken
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || beat_taken)) begin
      beat_taken = 1'b0;
      if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_beat = pending_beats.pop_front();
        in_valid_i  <= 1'b1;
        func_i      <= next_beat.func;
        key_in_i    <= next_beat.key;
        object_in_i <= next_beat.obj;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: random stall, or a long hold-off when one is requested
  always @(negedge clk_i) begin
    if (hold_seen != hold_req) begin
      hold_seen   <= hold_req;
      hold_left   <= HoldCycles;
      out_stall_i <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Monitor: check result beats, then predict for the accepted input beat
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          note_failure($sformatf("unexpected result st=%0d obj=%h min=%0d empty=%b",
                                 status_o, object_out_o, $signed(min_key_o), empty_res_o));
        end else begin
          want = expected_results.pop_front();
          if (status_o !== want.status || object_out_o !== want.obj ||
              min_key_o !== want.min_key || empty_res_o !== want.empty) begin
            note_failure($sformatf(
              "mismatch exp st=%0d obj=%h min=%0d empty=%b got st=%0d obj=%h min=%0d empty=%b",
              want.status, want.obj, want.min_key, want.empty,
              status_o, object_out_o, $signed(min_key_o), empty_res_o));
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        expected_results.push_back(fifo_min_step(op_e'(func_i), key_t'(key_in_i), object_in_i));
        beat_taken = 1'b1;
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("tb failed");
      $finish;
    end
  end

  task automatic add_beat(op_e f, key_t k, obj_t o);
    pending_beats.push_back('{func: f, key: k, obj: o});
  endtask

  // Key mix: narrow range for duplicates, full range, and corner values
  function automatic key_t pick_key();
    key_t corners[5] = '{32'sh7fffffff, 32'sh80000000, 32'sd0, -32'sd1, EmptyMin};
    case ($urandom_range(3))
      0, 3:    return key_t'($signed($urandom_range(20)) - 10);
      1:       return key_t'($urandom);
      default: return corners[$urandom_range(4)];
    endcase
  endfunction

  // Random beats in segments with a varying enqueue share
  task automatic add_random(int unsigned n);
    int unsigned enq_pct;
    enq_pct = 50;
    for (int unsigned i = 0; i < n; i++) begin
      if (i % 30 == 0) enq_pct = ($urandom_range(2) == 0) ? 15 : ($urandom_range(1) ? 50 : 85);
      add_beat(($urandom_range(99) < enq_pct) ? OP_ENQ : OP_DEQ, pick_key(), obj_t'($urandom));
    end
  endtask

  task automatic wait_drained();
    while (pending_beats.size() != 0 || in_valid_i || expected_results.size() != 0)
      @(posedge clk_i);
  endtask

  // Directed beats: empty, extremes, duplicates, refill
  task automatic add_directed();
    add_beat(OP_DEQ, 0, 0);
    add_beat(OP_ENQ, 32'sh7fffffff, 32'hffffffff);
    add_beat(OP_ENQ, 32'sh80000000, 32'h00000000);
    add_beat(OP_ENQ, 5, 32'h5a5a5a5a);
    add_beat(OP_ENQ, 5, 32'ha5a5a5a5);
    add_beat(OP_ENQ, EmptyMin, 32'h12345678);
    add_beat(OP_ENQ, -1, 32'h87654321);
    for (int i = 0; i < 6; i++) add_beat(OP_DEQ, 0, 0);
    add_beat(OP_DEQ, 0, 0);
    add_beat(OP_ENQ, 3, 32'h1);
    add_beat(OP_ENQ, 3, 32'h2);
    add_beat(OP_ENQ, 2, 32'h3);
    for (int i = 0; i < 4; i++) add_beat(OP_DEQ, 0, 0);
  endtask

  // Fill past full, then drain past empty
  task automatic add_fill_drain();
    for (int unsigned i = 0; i < Depth + 2; i++) add_beat(OP_ENQ, pick_key(), obj_t'($urandom));
    for (int unsigned i = 0; i < Depth + 2; i++) add_beat(OP_DEQ, pick_key(), obj_t'($urandom));
  endtask

  // Stimulus and end of run
  initial begin
    int unsigned send_pcts[NumPhases] = '{0, 64, 0, 17};
    int unsigned recv_pcts[NumPhases] = '{0, 0, 64, 17};
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    for (int p = 0; p < NumPhases; p++) begin
      send_idle_pct  = send_pcts[p];
      recv_stall_pct = recv_pcts[p];
      if (p == 0) begin
        add_directed();
        add_fill_drain();
      end
      add_random(RandPerPhase);
      if (p == 0) begin
        repeat (40) @(posedge clk_i);
        hold_req++;
      end
      wait_drained();
    end
    repeat (TailCycles) @(posedge clk_i);
    if (expected_results.size() != 0) note_failure("results still outstanding at end");
    if (fail_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
